// ===== rtl/bpws_pkg.sv =====
// Package with the configuration register map and shared types of the priority window sampler.
`timescale 1ns / 1ps

package bpws_pkg;

    localparam int CFG_BITS      = 30;
    localparam int CFG_ADDR_BITS = 1;
    localparam int COUNT_BITS    = 32;

    localparam logic [CFG_BITS-1:0] WIN_LEN_RESET             = CFG_BITS'(10000);
    localparam logic [CFG_BITS-1:0] CHECKPOINT_INTERVAL_RESET = CFG_BITS'(1000);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_WIN_LEN             = 1'b0,
        CFG_CHECKPOINT_INTERVAL = 1'b1
    } cfg_addr_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] win_len;
        logic [CFG_BITS-1:0] checkpoint_interval;
    } cfg_t;

endpackage

// ===== rtl/backward_priority_window_sampler.sv =====
// Top level of the priority window sampler: stream ports, configuration registers and pipeline.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// s_       in         s_tvalid / s_tready       tdata: start, end, priority; tuser: first
// m_       out        m_tvalid / m_tready       tdata: start, end, priority, count;
//                                               tuser: valid, checkpoint
// cfg_     in         cfg_wr_en                 cfg_addr, cfg_wr_data
//
// An edge is registered at the input and its result is registered in the output register, and
// one edge is taken every cycle while the result side does not stall.
// The sampler state update is a single pass of compares and adds between those registers.
// Reset is synchronous and active low; it clears the sampler state and loads the
// configuration reset values.
// A stall on the result side holds the output register and stops the input side in turn.

module backward_priority_window_sampler #(
    parameter int PRIORITY_BITS = 16,
    parameter int NODE_BITS     = 32,
    parameter int TIME_BITS     = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_node, end_node, priority_req, zero padding
    input  logic [((2*NODE_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,
    // first_of_stream
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_start, sample_end, sample_priority, valid_count, zero padding
    output logic [((2*NODE_BITS+PRIORITY_BITS+bpws_pkg::COUNT_BITS+7)/8)*8-1:0] m_tdata,
    // sample_valid, checkpoint_hit
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  bpws_pkg::cfg_addr_t                 cfg_addr,
    input  logic [bpws_pkg::CFG_BITS-1:0]       cfg_wr_data
);
    import bpws_pkg::*;

    localparam int M_FIELDS = 2*NODE_BITS + PRIORITY_BITS + COUNT_BITS;
    localparam int M_BITS   = ((M_FIELDS+7)/8)*8;

    cfg_t cfg_reg, cfg_next;

    logic                     in_valid_reg, in_valid_next;
    logic [NODE_BITS-1:0]     in_start_reg, in_end_reg;
    logic [PRIORITY_BITS-1:0] in_priority_reg;
    logic                     in_first_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [NODE_BITS-1:0]     out_start_reg, out_end_reg;
    logic [PRIORITY_BITS-1:0] out_priority_reg;
    logic [COUNT_BITS-1:0]    out_count_reg;
    logic                     out_sample_valid_reg, out_hit_reg;

    logic [NODE_BITS-1:0]     res_start, res_end;
    logic [PRIORITY_BITS-1:0] res_priority;
    logic [COUNT_BITS-1:0]    res_count;
    logic                     res_sample_valid, res_hit;

    logic pipe_ready, fire, s_take;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_WIN_LEN:             cfg_next.win_len = cfg_wr_data;
                CFG_CHECKPOINT_INTERVAL: cfg_next.checkpoint_interval = cfg_wr_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_len             <= WIN_LEN_RESET;
            cfg_reg.checkpoint_interval <= CHECKPOINT_INTERVAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign pipe_ready = !out_valid_reg || m_tready;
    assign fire       = in_valid_reg && pipe_ready;
    assign s_tready   = !in_valid_reg || pipe_ready;
    assign s_take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_start_reg    <= s_tdata[NODE_BITS-1:0];
            in_end_reg      <= s_tdata[2*NODE_BITS-1:NODE_BITS];
            in_priority_reg <= s_tdata[2*NODE_BITS+PRIORITY_BITS-1:2*NODE_BITS];
            in_first_reg    <= s_tuser;
        end
        if (fire) begin
            out_start_reg        <= res_start;
            out_end_reg          <= res_end;
            out_priority_reg     <= res_priority;
            out_count_reg        <= res_count;
            out_sample_valid_reg <= res_sample_valid;
            out_hit_reg          <= res_hit;
        end
    end

    bpws_core #(
        .PRIORITY_BITS (PRIORITY_BITS),
        .NODE_BITS     (NODE_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .step_en             (fire),
        .in_start_node       (in_start_reg),
        .in_end_node         (in_end_reg),
        .in_priority_req     (in_priority_reg),
        .in_first_of_stream  (in_first_reg),
        .res_sample_start    (res_start),
        .res_sample_end      (res_end),
        .res_sample_priority (res_priority),
        .res_sample_valid    (res_sample_valid),
        .res_valid_count     (res_count),
        .res_checkpoint_hit  (res_hit)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_BITS'({out_count_reg, out_priority_reg, out_end_reg, out_start_reg});
    assign m_tuser  = {out_hit_reg, out_sample_valid_reg};

`ifndef NO_ASSERTIONS
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("A processed edge did not produce a result transaction.");

    a_hit_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("Checkpoint mark raised on an invalid sample.");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("Input side stalled with an empty input register.");
`endif

endmodule

// ===== rtl/bpws_core.sv =====
// Sampler state registers and the combinational update applied to each edge.
`timescale 1ns / 1ps

module bpws_core #(
    parameter int PRIORITY_BITS = 16,
    parameter int NODE_BITS     = 32,
    parameter int TIME_BITS     = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bpws_pkg::cfg_t                cfg,
    input  logic                          step_en,
    input  logic [NODE_BITS-1:0]          in_start_node,
    input  logic [NODE_BITS-1:0]          in_end_node,
    input  logic [PRIORITY_BITS-1:0]      in_priority_req,
    input  logic                          in_first_of_stream,
    output logic [NODE_BITS-1:0]          res_sample_start,
    output logic [NODE_BITS-1:0]          res_sample_end,
    output logic [PRIORITY_BITS-1:0]      res_sample_priority,
    output logic                          res_sample_valid,
    output logic [bpws_pkg::COUNT_BITS-1:0] res_valid_count,
    output logic                          res_checkpoint_hit
);
    import bpws_pkg::*;

    localparam int CB = ((TIME_BITS > CFG_BITS + 1) ? TIME_BITS : CFG_BITS + 1) + 1;

    logic                     held_present_reg,  held_present_next;
    logic [NODE_BITS-1:0]     held_start_reg,    held_start_next;
    logic [NODE_BITS-1:0]     held_end_reg,      held_end_next;
    logic [PRIORITY_BITS-1:0] held_priority_reg, held_priority_next;
    logic [TIME_BITS-1:0]     held_time_reg,     held_time_next;
    logic                     probe_present_reg, probe_present_next;
    logic [PRIORITY_BITS-1:0] probe_priority_reg, probe_priority_next;
    logic [TIME_BITS-1:0]     probe_time_reg,    probe_time_next;
    logic [TIME_BITS-1:0]     item_time_reg,     item_time_next;
    logic [COUNT_BITS-1:0]    good_count_reg,    good_count_next;
    logic [CFG_BITS-1:0]      tick_phase_reg,    tick_phase_next;

    logic                     cur_held_present, cur_probe_present;
    logic [PRIORITY_BITS-1:0] cur_held_priority, cur_probe_priority;
    logic [TIME_BITS-1:0]     cur_held_time, cur_probe_time, cur_time;
    logic [COUNT_BITS-1:0]    cur_count;
    logic [CFG_BITS-1:0]      cur_phase;
    logic [CB-1:0]            time_x, window_x, life_x;
    logic                     age, expire, take, valid;
    logic                     aged_held_present, aged_probe_present;
    logic [PRIORITY_BITS-1:0] aged_probe_priority;
    logic [TIME_BITS-1:0]     aged_probe_time;
    logic [CFG_BITS:0]        phase_inc;

    always_comb begin
        cur_held_present   = in_first_of_stream ? 1'b0 : held_present_reg;
        cur_held_priority  = in_first_of_stream ? '0 : held_priority_reg;
        cur_held_time      = in_first_of_stream ? '0 : held_time_reg;
        cur_probe_present  = in_first_of_stream ? 1'b0 : probe_present_reg;
        cur_probe_priority = in_first_of_stream ? '0 : probe_priority_reg;
        cur_probe_time     = in_first_of_stream ? '0 : probe_time_reg;
        cur_time           = in_first_of_stream ? '0 : item_time_reg;
        cur_count          = in_first_of_stream ? '0 : good_count_reg;
        cur_phase          = in_first_of_stream ? '0 : tick_phase_reg;

        time_x   = CB'(cur_time);
        window_x = CB'(cfg.win_len);
        life_x   = (window_x == '0) ? '0 : CB'(window_x + window_x - CB'(1));

        // The held sample turns into the test edge once it is a full window old.
        age                 = cur_held_present && (CB'(cur_held_time) + window_x <= time_x);
        aged_held_present   = cur_held_present && !age;
        aged_probe_present  = age ? 1'b1 : cur_probe_present;
        aged_probe_priority = age ? cur_held_priority : cur_probe_priority;
        aged_probe_time     = age ? cur_held_time : cur_probe_time;

        expire = aged_probe_present && (CB'(aged_probe_time) + life_x <= time_x);
        probe_present_next  = aged_probe_present && !expire;
        probe_priority_next = aged_probe_priority;
        probe_time_next     = aged_probe_time;

        take = !aged_held_present || (in_priority_req >= cur_held_priority);
        held_present_next  = 1'b1;
        held_start_next    = take ? in_start_node : held_start_reg;
        held_end_next      = take ? in_end_node : held_end_reg;
        held_priority_next = take ? in_priority_req : cur_held_priority;
        held_time_next     = take ? cur_time : cur_held_time;

        valid = !probe_present_next || (held_priority_next >= aged_probe_priority);

        good_count_next = cur_count;
        if (valid && (time_x >= window_x + window_x) && (cur_count != '1)) begin
            good_count_next = cur_count + COUNT_BITS'(1);
        end

        item_time_next = (cur_time != '1) ? cur_time + TIME_BITS'(1) : cur_time;

        phase_inc       = {1'b0, cur_phase} + (CFG_BITS + 1)'(1);
        tick_phase_next = (phase_inc >= {1'b0, cfg.checkpoint_interval}) ?
                          '0 : phase_inc[CFG_BITS-1:0];

        res_sample_start    = held_start_next;
        res_sample_end      = held_end_next;
        res_sample_priority = held_priority_next;
        res_sample_valid    = valid;
        res_valid_count     = good_count_next;
        res_checkpoint_hit  = valid && (cfg.checkpoint_interval != '0) && (cur_phase == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_present_reg   <= 1'b0;
            held_start_reg     <= '0;
            held_end_reg       <= '0;
            held_priority_reg  <= '0;
            held_time_reg      <= '0;
            probe_present_reg  <= 1'b0;
            probe_priority_reg <= '0;
            probe_time_reg     <= '0;
            item_time_reg      <= '0;
            good_count_reg     <= '0;
            tick_phase_reg     <= '0;
        end else if (step_en) begin
            held_present_reg   <= held_present_next;
            held_start_reg     <= held_start_next;
            held_end_reg       <= held_end_next;
            held_priority_reg  <= held_priority_next;
            held_time_reg      <= held_time_next;
            probe_present_reg  <= probe_present_next;
            probe_priority_reg <= probe_priority_next;
            probe_time_reg     <= probe_time_next;
            item_time_reg      <= item_time_next;
            good_count_reg     <= good_count_next;
            tick_phase_reg     <= tick_phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_first_restarts_time: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && in_first_of_stream |=> item_time_reg == TIME_BITS'(1))
        else $error("Time did not restart after a first-of-stream edge.");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !in_first_of_stream |=> good_count_reg >= $past(good_count_reg))
        else $error("Valid count decreased within a stream.");

    a_sample_held: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> held_present_reg)
        else $error("No sample is held after an edge was processed.");
`endif

endmodule
